// File: hdl/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg: shared constants for the CRC-8 frame receiver
// Frame markers, store sizing, CRC polynomial and register indexes.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

	localparam int MAX_FRAME   = 32;
	localparam int STORE_DEPTH = MAX_FRAME - 1;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_FRAME);

	localparam logic [7:0] START_MARK = 8'h3E;
	localparam logic [7:0] END_MARK   = 8'h00;
	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam int         MIN_BODY   = 3;

	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

endpackage

// File: hdl/crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver: length-prefixed serial deframer with CRC-8/SMBus check
//
// Input words carry either a received byte (opcode 0) or a timer tick
// (opcode 1). Frames are start 0x3E, length, body, CRC-8 (poly 0x07, init 0,
// over length and body), end 0x00. A frame whose node type and node id match
// the configured registers emits one output word per payload byte, each with
// the command byte, or one empty word; last marks the final word.
// Start, CRC, end, tick and oversized length words are taken without a stall.
// Other length and body bytes are accepted and then run through the bit-serial
// CRC shifter, during which in_stall is high. After the end byte each payload
// word passes through RAM read, output load and handoff, and an empty word
// goes straight to handoff, where out_stall can hold it; no input is taken
// until the last word of the frame has left.
// Reset returns to hunting for the start byte with registers at node type 0,
// node id 0 and a timeout of 500 ticks. The body store needs no clearing.
// While out_stall is high the output word holds and the input stays stalled.
// ----------------------------------------------------------------------------
module crc8_frame_receiver (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [7:0]                            rx_byte,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [7:0]                            command,
	output logic [7:0]                            payload_byte,
	output logic                                  byte_present,
	output logic                                  last,
	input  logic                                  cfg_we,
	input  logic [crc8fr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crc8fr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import crc8fr_pkg::*;

	typedef enum logic [3:0] {
		S_HUNT,
		S_LEN,
		S_BODY,
		S_CRC,
		S_END,
		S_CALC,
		S_FETCH,
		S_LOAD,
		S_DRAIN
	} state_t;

	state_t             state_q;
	state_t             ret_q;
	logic [CNT_W-1:0]   len_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [7:0]         crc_q;
	logic [2:0]         bit_q;
	logic [15:0]        tick_q;
	logic [7:0]         type_q;
	logic [7:0]         id_q;
	logic [7:0]         cmd_q;
	logic [ADDR_W-1:0]  emit_idx_q;
	logic [7:0]         node_type_q;
	logic [7:0]         node_id_q;
	logic [15:0]        timeout_q;
	logic               out_valid_q;
	logic [7:0]         payload_q;
	logic               present_q;
	logic               last_q;

	logic               in_take;
	logic               byte_take;
	logic               tick_take;
	logic               out_take;
	logic [16:0]        tick_next;
	logic [CNT_W-1:0]   cnt_next;
	logic               frame_ok;
	logic               ram_we;
	logic               ram_re;
	logic [7:0]         ram_rdata;

	assign in_stall  = !(state_q == S_HUNT || state_q == S_LEN || state_q == S_BODY ||
		state_q == S_CRC || state_q == S_END);
	assign in_take   = in_valid && !in_stall;
	assign byte_take = in_take && (opcode == OP_BYTE);
	assign tick_take = in_take && (opcode == OP_TICK);
	assign out_take  = out_valid_q && !out_stall;
	assign tick_next = {1'b0, tick_q} + 17'd1;
	assign cnt_next  = cnt_q + CNT_W'(1);
	assign frame_ok  = (len_q >= CNT_W'(MIN_BODY)) && (type_q == node_type_q) &&
		(id_q == node_id_q);
	assign ram_we    = byte_take && (state_q == S_BODY);
	assign ram_re    = (state_q == S_FETCH);

	crc8fr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (ram_re),
		.raddr(emit_idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_type_q <= '0;
			node_id_q   <= '0;
			timeout_q   <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_TYPE: node_type_q <= cfg_data[7:0];
				CFG_NODE_ID:   node_id_q   <= cfg_data[7:0];
				CFG_TIMEOUT:   timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_HUNT;
			ret_q       <= S_HUNT;
			len_q       <= '0;
			cnt_q       <= '0;
			crc_q       <= '0;
			bit_q       <= '0;
			tick_q      <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
			payload_q   <= '0;
			present_q   <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (tick_take && (state_q == S_BODY || state_q == S_CRC || state_q == S_END)) begin
				if (tick_next > {1'b0, timeout_q}) begin
					state_q <= S_HUNT;
				end else begin
					tick_q <= tick_next[15:0];
				end
			end
			unique case (state_q)
				S_HUNT: begin
					if (byte_take && rx_byte == START_MARK) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					if (byte_take) begin
						if (rx_byte > 8'(STORE_DEPTH)) begin
							state_q <= S_HUNT;
						end else begin
							len_q   <= rx_byte[CNT_W-1:0];
							cnt_q   <= '0;
							tick_q  <= '0;
							crc_q   <= rx_byte;
							bit_q   <= '0;
							ret_q   <= (rx_byte == 8'd0) ? S_CRC : S_BODY;
							state_q <= S_CALC;
						end
					end
				end
				S_BODY: begin
					if (byte_take) begin
						crc_q   <= crc_q ^ rx_byte;
						cnt_q   <= cnt_next;
						bit_q   <= '0;
						ret_q   <= (cnt_next >= len_q) ? S_CRC : S_BODY;
						state_q <= S_CALC;
					end
				end
				S_CRC: begin
					if (byte_take) begin
						state_q <= (rx_byte == crc_q) ? S_END : S_HUNT;
					end
				end
				S_END: begin
					if (byte_take) begin
						state_q <= S_HUNT;
						if (rx_byte == END_MARK && frame_ok) begin
							if (len_q == CNT_W'(MIN_BODY)) begin
								out_valid_q <= 1'b1;
								payload_q   <= '0;
								present_q   <= 1'b0;
								last_q      <= 1'b1;
								state_q     <= S_DRAIN;
							end else begin
								emit_idx_q <= ADDR_W'(MIN_BODY);
								state_q    <= S_FETCH;
							end
						end
					end
				end
				S_CALC: begin
					crc_q <= crc_q[7] ? ({crc_q[6:0], 1'b0} ^ CRC_POLY) : {crc_q[6:0], 1'b0};
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						state_q <= ret_q;
					end
				end
				S_FETCH: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					payload_q   <= ram_rdata;
					present_q   <= 1'b1;
					last_q      <= (CNT_W'(emit_idx_q) == len_q - CNT_W'(1));
					state_q     <= S_DRAIN;
				end
				S_DRAIN: begin
					if (out_take) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_HUNT;
						end else begin
							emit_idx_q <= emit_idx_q + ADDR_W'(1);
							state_q    <= S_FETCH;
						end
					end
				end
				default: state_q <= S_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			unique case (cnt_q)
				CNT_W'(0): type_q <= rx_byte;
				CNT_W'(1): id_q   <= rx_byte;
				CNT_W'(2): cmd_q  <= rx_byte;
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign command      = cmd_q;
	assign payload_byte = payload_q;
	assign byte_present = present_q;
	assign last         = last_q;

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while an output word is pending");

	a_body_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && opcode == OP_BYTE && state_q == S_BODY) |=> in_stall)
		else $error("body byte not followed by CRC shift cycles");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BODY) |-> (cnt_q < len_q))
		else $error("body count reached frame length while still in body");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> (!out_valid && state_q == S_HUNT))
		else $error("frame emission did not end after last word");

endmodule

// File: hdl/crc8fr_ram.sv
// ----------------------------------------------------------------------------
// crc8fr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module crc8fr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: bench/tb_crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// tb_crc8_frame_receiver: self-checking bench for the CRC-8 frame receiver
// A driver and a monitor run on the valid/stall channels with random gaps.
// A cycle-free deframer model predicts every output word.
// Directed frames cover the corner cases. Random traffic follows under
// several register settings, with one long output hold-off included.
// ----------------------------------------------------------------------------
module tb_crc8_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	import crc8fr_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int STUCK_LIMIT   = 1000;
	localparam int LONG_HOLD     = 80;

	typedef enum logic [2:0] {RX_HUNT, RX_LEN, RX_BODY, RX_CRC, RX_END} rx_state_t;
	typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_END, FLAW_CUT} frame_flaw_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} rx_word_t;

	typedef struct packed {
		logic [7:0] command;
		logic [7:0] payload;
		logic       present;
		logic       last_word;
	} cmd_word_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  opcode = OP_BYTE;
	logic [7:0]            rx_byte = 8'h00;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            command;
	logic [7:0]            payload_byte;
	logic                  byte_present;
	logic                  last;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_NODE_TYPE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register mirror
	logic [7:0]  cfg_node_type = 8'h00;
	logic [7:0]  cfg_node_id = 8'h00;
	logic [15:0] cfg_timeout = TIMEOUT_RESET;

	// deframer model state
	rx_state_t   rx_state = RX_HUNT;
	logic [5:0]  body_len = '0;
	logic [5:0]  body_pos = '0;
	logic [7:0]  crc_acc = '0;
	logic [15:0] ticks_seen = '0;
	logic [7:0]  body_mem [STORE_DEPTH];

	rx_word_t  pending_rx [$];
	cmd_word_t awaited_cmds [$];
	rx_word_t  next_word;
	cmd_word_t due;

	int  words_queued = 0;
	int  words_in = 0;
	int  ticks_in = 0;
	int  words_out = 0;
	int  frames_accepted = 0;
	int  mismatches = 0;
	int  tick_odds = 0;
	int  gap_left = 0;
	int  hold_left = 0;
	int  hold_next;
	int  stuck_cycles = 0;
	bit  sender_burst = 1'b0;
	bit  recv_burst = 1'b0;
	bit  long_hold_armed = 1'b0;
	bit  long_hold_done = 1'b0;

	crc8_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command      (command),
		.payload_byte (payload_byte),
		.byte_present (byte_present),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] crc8_next(logic [7:0] acc, logic [7:0] b);
		logic [7:0] v;
		v = acc ^ b;
		for (int i = 0; i < 8; i++)
			v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
		return v;
	endfunction

	task automatic deframe_word(logic op, logic [7:0] b);
		logic [16:0] next_ticks;
		cmd_word_t   w;
		int          n;
		if (op == OP_TICK) begin
			ticks_in++;
			if (rx_state == RX_BODY || rx_state == RX_CRC || rx_state == RX_END) begin
				next_ticks = {1'b0, ticks_seen} + 17'd1;
				if (next_ticks > {1'b0, cfg_timeout})
					rx_state = RX_HUNT;
				else
					ticks_seen = next_ticks[15:0];
			end
			return;
		end
		case (rx_state)
		RX_HUNT: begin
			if (b == START_MARK)
				rx_state = RX_LEN;
		end
		RX_LEN: begin
			if (b > STORE_DEPTH) begin
				rx_state = RX_HUNT;
			end else begin
				body_len = b[5:0];
				body_pos = '0;
				ticks_seen = '0;
				crc_acc = crc8_next(8'h00, b);
				rx_state = (b == 8'h00) ? RX_CRC : RX_BODY;
			end
		end
		RX_BODY: begin
			if (body_pos < STORE_DEPTH)
				body_mem[body_pos] = b;
			crc_acc = crc8_next(crc_acc, b);
			body_pos = body_pos + 6'd1;
			if (body_pos >= body_len)
				rx_state = RX_CRC;
		end
		RX_CRC: begin
			rx_state = (b == crc_acc) ? RX_END : RX_HUNT;
		end
		RX_END: begin
			rx_state = RX_HUNT;
			if (b == END_MARK && body_len >= MIN_BODY && body_mem[0] == cfg_node_type &&
					body_mem[1] == cfg_node_id) begin
				frames_accepted++;
				n = body_len - MIN_BODY;
				w.command = body_mem[2];
				if (n == 0) begin
					w.payload = 8'h00;
					w.present = 1'b0;
					w.last_word = 1'b1;
					awaited_cmds.push_back(w);
				end
				for (int k = 0; k < n; k++) begin
					w.payload = body_mem[MIN_BODY + k];
					w.present = 1'b1;
					w.last_word = (k + 1 == n);
					awaited_cmds.push_back(w);
				end
			end
		end
		default: rx_state = RX_HUNT;
		endcase
	endtask

	function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %02h, got %02h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= OP_BYTE;
			rx_byte <= 8'h00;
			gap_left <= 0;
			rx_state = RX_HUNT;
			body_len = '0;
			body_pos = '0;
			crc_acc = '0;
			ticks_seen = '0;
		end else begin
			if (in_valid && !in_stall) begin
				deframe_word(opcode, rx_byte);
				words_in++;
				if (words_in % 24 == 0)
					sender_burst = ($urandom_range(0, 2) == 0);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_rx.size() != 0) begin
					next_word = pending_rx.pop_front();
					in_valid <= 1'b1;
					opcode <= next_word.op;
					rx_byte <= next_word.data;
					gap_left <= sender_burst ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_cmds.size() == 0) begin
					$display("%0t ns: unexpected word command %02h payload %02h present %0b last %0b",
						$time, command, payload_byte, byte_present, last);
					mismatches++;
				end else begin
					due = awaited_cmds.pop_front();
					check_field("command", due.command, command);
					check_field("payload_byte", due.payload, payload_byte);
					check_field("byte_present", 8'(due.present), 8'(byte_present));
					check_field("last", 8'(due.last_word), 8'(last));
				end
				words_out++;
				if (words_out % 16 == 0)
					recv_burst = ($urandom_range(0, 2) == 0);
				if (long_hold_armed && !long_hold_done) begin
					hold_next = LONG_HOLD;
					long_hold_done = 1'b1;
				end else begin
					hold_next = recv_burst ? 0 : $urandom_range(0, 5);
				end
			end else begin
				hold_next = (hold_left != 0) ? hold_left - 1 : 0;
			end
			hold_left <= hold_next;
			out_stall <= (hold_next != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles, %0d words still awaited",
				$time, STUCK_LIMIT, awaited_cmds.size());
			$display("Test completed with failures");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic push_word(logic op, logic [7:0] data);
		rx_word_t w;
		w.op = op;
		w.data = data;
		pending_rx.push_back(w);
		words_queued++;
	endtask

	task automatic maybe_tick();
		if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1)
			push_word(OP_TICK, 8'($urandom));
	endtask

	task automatic queue_frame(int len, logic [7:0] ntype, logic [7:0] nid, int fill,
			frame_flaw_t flaw);
		logic [7:0] crc;
		logic [7:0] b;
		int         cut;
		cut = (len > 0) ? $urandom_range(0, len - 1) : 0;
		crc = crc8_next(8'h00, 8'(len));
		push_word(OP_BYTE, START_MARK);
		push_word(OP_BYTE, 8'(len));
		maybe_tick();
		for (int i = 0; i < len; i++) begin
			if (flaw == FLAW_CUT && i == cut) begin
				if (cfg_timeout <= 16)
					repeat (cfg_timeout + 1) push_word(OP_TICK, 8'($urandom));
				return;
			end
			if (i == 0)
				b = ntype;
			else if (i == 1)
				b = nid;
			else
				b = (fill < 0) ? 8'($urandom) : 8'(fill);
			crc = crc8_next(crc, b);
			push_word(OP_BYTE, b);
			maybe_tick();
		end
		push_word(OP_BYTE, (flaw == FLAW_CRC) ? crc ^ 8'($urandom_range(1, 255)) : crc);
		maybe_tick();
		push_word(OP_BYTE, (flaw == FLAW_END) ? 8'($urandom_range(1, 255)) : END_MARK);
	endtask

	task automatic queue_random_traffic(int words);
		int         stop_at;
		int         roll;
		int         len;
		logic [7:0] dt;
		logic [7:0] di;
		stop_at = words_queued + words;
		while (words_queued < stop_at) begin
			roll = $urandom_range(0, 99);
			len = ($urandom_range(0, 19) == 0) ? STORE_DEPTH : $urandom_range(MIN_BODY, 8);
			if (roll < 55) begin
				queue_frame(len, cfg_node_type, cfg_node_id, -1, FLAW_NONE);
			end else if (roll < 63) begin
				dt = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'h00;
				di = (dt == 8'h00) ? 8'($urandom_range(1, 255)) : 8'($urandom);
				queue_frame(len, cfg_node_type ^ dt, cfg_node_id ^ di, -1, FLAW_NONE);
			end else if (roll < 70) begin
				queue_frame(len, cfg_node_type, cfg_node_id, -1, FLAW_CRC);
			end else if (roll < 76) begin
				queue_frame(len, cfg_node_type, cfg_node_id, -1, FLAW_END);
			end else if (roll < 82) begin
				queue_frame($urandom_range(0, MIN_BODY - 1), cfg_node_type, cfg_node_id, -1,
					FLAW_NONE);
			end else if (roll < 87) begin
				push_word(OP_BYTE, START_MARK);
				push_word(OP_BYTE, 8'($urandom_range(STORE_DEPTH + 1, 255)));
			end else if (roll < 94) begin
				repeat ($urandom_range(1, 4))
					push_word($urandom_range(0, 1) ? OP_TICK : OP_BYTE, 8'($urandom));
			end else begin
				queue_frame(len, cfg_node_type, cfg_node_id, -1, FLAW_CUT);
			end
		end
	endtask

	task automatic settle();
		while (pending_rx.size() != 0 || in_valid || awaited_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_NODE_TYPE: cfg_node_type = value[7:0];
		CFG_NODE_ID:   cfg_node_id = value[7:0];
		CFG_TIMEOUT:   cfg_timeout = value;
		default: ;
		endcase
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// corner cases under reset register values
		push_word(OP_TICK, 8'hFF);
		push_word(OP_BYTE, START_MARK);
		push_word(OP_TICK, 8'h00);
		push_word(OP_BYTE, 8'(STORE_DEPTH + 1));
		push_word(OP_BYTE, START_MARK);
		push_word(OP_BYTE, 8'h00);
		push_word(OP_BYTE, START_MARK);
		push_word(OP_BYTE, END_MARK);
		push_word(OP_BYTE, START_MARK);
		push_word(OP_BYTE, 8'h00);
		push_word(OP_BYTE, 8'h00);
		push_word(OP_BYTE, END_MARK);
		queue_frame(MIN_BODY, cfg_node_type, cfg_node_id, 8'h00, FLAW_NONE);
		queue_frame(MIN_BODY + 1, cfg_node_type, cfg_node_id, 8'hFF, FLAW_NONE);
		queue_frame(MIN_BODY, cfg_node_type ^ 8'h01, cfg_node_id, -1, FLAW_NONE);
		queue_frame(MIN_BODY, cfg_node_type, cfg_node_id ^ 8'h80, -1, FLAW_NONE);
		queue_frame(MIN_BODY, cfg_node_type, cfg_node_id, -1, FLAW_END);
		settle();

		set_reg(CFG_NODE_TYPE, 16'h00FF);
		set_reg(CFG_NODE_ID, 16'h00FF);
		set_reg(CFG_TIMEOUT, 16'hFFFF);
		tick_odds = 8;
		queue_random_traffic(25);
		settle();

		set_reg(CFG_NODE_TYPE, 16'h00A5);
		set_reg(CFG_NODE_ID, 16'h003C);
		set_reg(CFG_TIMEOUT, 16'd1);
		tick_odds = 0;
		push_word(OP_BYTE, START_MARK);
		push_word(OP_BYTE, 8'(MIN_BODY));
		push_word(OP_BYTE, cfg_node_type);
		push_word(OP_TICK, 8'h5A);
		push_word(OP_TICK, 8'hA5);
		queue_frame(MIN_BODY + 2, cfg_node_type, cfg_node_id, -1, FLAW_NONE);
		tick_odds = 5;
		queue_random_traffic(25);
		settle();

		set_reg(CFG_NODE_TYPE, 16'h003E);
		set_reg(CFG_NODE_ID, 16'h0000);
		set_reg(CFG_TIMEOUT, 16'd4);
		tick_odds = 6;
		long_hold_armed = 1'b1;
		queue_frame(STORE_DEPTH, cfg_node_type, cfg_node_id, -1, FLAW_NONE);
		queue_random_traffic(25);
		settle();

		set_reg(CFG_NODE_TYPE, 16'h0000);
		set_reg(CFG_NODE_ID, 16'h0080);
		set_reg(CFG_TIMEOUT, TIMEOUT_RESET);
		tick_odds = 10;
		queue_random_traffic(25);
		settle();

		$display("Sent %0d input words (%0d ticks); checked %0d output words from %0d frames",
			words_in, ticks_in, words_out, frames_accepted);
		$display("Five register settings, node bytes 00/FF, timeouts 1 to 65535, one long hold");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
hdl/crc8fr_pkg.sv
hdl/crc8fr_ram.sv
hdl/crc8_frame_receiver.sv
bench/tb_crc8_frame_receiver.sv
